// ===== rtl/level_priority_interrupt_controller_defines.svh =====
// ----------------------------------------------------------------------------
// Level/priority interrupt controller assertion macros
// Shared helpers for the concurrent checks in the controller RTL.
// ----------------------------------------------------------------------------
`ifndef LEVEL_PRIORITY_INTERRUPT_CONTROLLER_DEFINES_SVH
`define LEVEL_PRIORITY_INTERRUPT_CONTROLLER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define LPIC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lpic same-cycle check failed");

// Next-cycle implication, disabled during reset
`define LPIC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lpic next-cycle check failed");

`endif

// ===== rtl/lpic_pkg.sv =====
// ----------------------------------------------------------------------------
// lpic_pkg
// Constants, record types and state codes of the interrupt controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lpic_pkg;

  localparam int SOURCE_COUNT = 64;
  localparam int CTL_BITS     = 4;
  localparam int SRC_W        = $clog2(SOURCE_COUNT);

  localparam logic [12:0] ADDR_CFG      = 13'h000;
  localparam logic [12:0] ADDR_INFO     = 13'h004;
  localparam logic [12:0] ADDR_THRESH   = 13'h00B;
  localparam logic [12:0] ADDR_SRC_BASE = 13'h1000;

  localparam logic [31:0] INFO_WORD = 32'(CTL_BITS) << 21;

  // word modes
  localparam logic [1:0] MODE_READ  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_LINE  = 2'd2;
  localparam logic [1:0] MODE_CLAIM = 2'd3;

  // per-source byte offsets
  localparam logic [1:0] SUB_PEND = 2'd0;
  localparam logic [1:0] SUB_EN   = 2'd1;
  localparam logic [1:0] SUB_ATTR = 2'd2;
  localparam logic [1:0] SUB_CTL  = 2'd3;

  // one memory entry per source
  typedef struct packed {
    logic       pend;
    logic       last;
    logic [7:0] en;
    logic [7:0] attr;
    logic [7:0] ctl;
  } src_rec_t;

  localparam int REC_W = $bits(src_rec_t);

  // running winner of the scan
  typedef struct packed {
    logic             found;
    logic [SRC_W-1:0] id;
    logic             vec;
    logic [7:0]       lvl;
  } arb_res_t;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_MOD,
    ST_SCAN,
    ST_DRAIN,
    ST_FIN
  } state_e;

endpackage

// ===== rtl/lpic_ram.sv =====
// ----------------------------------------------------------------------------
// lpic_ram
// Single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpic_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 26
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== rtl/lpic_arb.sv =====
// ----------------------------------------------------------------------------
// lpic_arb
// Decodes one source record a cycle and keeps the best candidate so far.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpic_arb (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           clear_i,
  input  logic                           valid_i,
  input  logic [lpic_pkg::SRC_W-1:0]     id_i,
  input  lpic_pkg::src_rec_t             rec_i,
  input  logic [7:0]                     cfg_i,
  input  logic [7:0]                     thresh_i,
  output lpic_pkg::arb_res_t             res_o
);

  lpic_pkg::arb_res_t res_d, res_q;
  logic [15:0] key_d, key_q;
  logic [3:0]  nbits;
  logic [3:0]  pw;
  logic [8:0]  pmask;
  logic [7:0]  lvl;
  logic [7:0]  prio;
  logic [15:0] key;
  logic        cand;

  // level/priority decode of the record under test
  always_comb begin
    nbits = (cfg_i[4:1] > 4'(lpic_pkg::CTL_BITS)) ? 4'(lpic_pkg::CTL_BITS) : cfg_i[4:1];
    pw    = 4'(lpic_pkg::CTL_BITS) - nbits;
    pmask = (9'd1 << pw) - 9'd1;
    if (nbits == 4'd0) begin
      lvl = 8'hFF;
    end else begin
      lvl = (rec_i.ctl & (8'hFF << (4'd8 - nbits))) | (8'hFF >> nbits);
    end
    prio = (rec_i.ctl >> (8 - lpic_pkg::CTL_BITS)) & pmask[7:0];
    key  = {lvl, prio};
    cand = valid_i && rec_i.pend && rec_i.en[0] && (lvl >= thresh_i);
  end

  // running best: ascending ids, ties go to the later id
  always_comb begin
    res_d = res_q;
    key_d = key_q;
    if (clear_i) begin
      res_d = '0;
      key_d = '0;
    end else if (cand && (!res_q.found || key >= key_q)) begin
      res_d.found = 1'b1;
      res_d.id    = id_i;
      res_d.vec   = rec_i.attr[0];
      res_d.lvl   = lvl;
      key_d       = key;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
      key_q <= '0;
    end else begin
      res_q <= res_d;
      key_q <= key_d;
    end
  end

  assign res_o = res_q;

endmodule

// ===== rtl/level_priority_interrupt_controller.sv =====
// Flow: a word is taken only in the idle state, so the next word waits until the
// last one is through; the ranking scan reads every source entry through the
// single read port of the state RAM, and a result waiting on out_ready_i holds
// the next word off.
// Reset: rst_ni is asynchronous; after release a clearing pass zeroes every entry
// of the source RAM while in_ready_o stays low.
// ----------------------------------------------------------------------------
// level_priority_interrupt_controller
// Interrupt controller with per-source state in a RAM and a serial ranking scan.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "level_priority_interrupt_controller_defines.svh"

module level_priority_interrupt_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [12:0] address_i,
  input  logic [7:0]  write_data_i,
  input  logic [5:0]  source_i,
  input  logic        line_level_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] read_data_o,
  output logic        irq_valid_o,
  output logic [5:0]  irq_id_o,
  output logic        irq_vectored_o,
  output logic [7:0]  irq_level_o
);

  localparam int SW = lpic_pkg::SRC_W;

  lpic_pkg::state_e   state_d, state_q;
  logic [SW-1:0]      cnt_d, cnt_q;
  logic [1:0]         mode_q;
  logic [12:0]        addr_q;
  logic [7:0]         wd_q;
  logic               lvl_q;
  logic               hit_d, hit_q;
  logic [SW-1:0]      idx_d, idx_q;
  logic [7:0]         cfg_d, cfg_q;
  logic [7:0]         thr_d, thr_q;
  logic [31:0]        rd_d, rd_q;
  logic               scan_vld_d, scan_vld_q;
  logic [SW-1:0]      scan_id_q;
  logic               out_vld_d, out_vld_q;
  logic               load_out;
  logic               accept;

  logic               ram_we, ram_re;
  logic [SW-1:0]      ram_waddr, ram_raddr;
  lpic_pkg::src_rec_t ram_wdata, ram_rdata, rec_new;
  lpic_pkg::arb_res_t best;
  logic               arb_clear;
  logic [31:0]        out_rd_q;
  lpic_pkg::arb_res_t out_res_q;

  assign accept = in_valid_i && in_ready_o;

  // source index of the incoming word
  always_comb begin
    hit_d = 1'b0;
    idx_d = '0;
    unique case (mode_i)
      lpic_pkg::MODE_READ, lpic_pkg::MODE_WRITE: begin
        hit_d = (address_i >= lpic_pkg::ADDR_SRC_BASE) &&
                (32'(address_i[11:2]) < lpic_pkg::SOURCE_COUNT);
        idx_d = address_i[2 +: SW];
      end
      lpic_pkg::MODE_LINE, lpic_pkg::MODE_CLAIM: begin
        hit_d = 32'(source_i) < lpic_pkg::SOURCE_COUNT;
        idx_d = source_i[SW-1:0];
      end
      default: ;
    endcase
  end

  // read-modify-write of the addressed entry, plus read data and global registers
  always_comb begin
    rec_new = ram_rdata;
    rd_d    = '0;
    cfg_d   = cfg_q;
    thr_d   = thr_q;
    if (addr_q >= lpic_pkg::ADDR_SRC_BASE) begin
      if (mode_q == lpic_pkg::MODE_READ && hit_q) begin
        unique case (addr_q[1:0])
          lpic_pkg::SUB_PEND: rd_d = 32'(ram_rdata.pend);
          lpic_pkg::SUB_EN:   rd_d = 32'(ram_rdata.en);
          lpic_pkg::SUB_ATTR: rd_d = 32'(ram_rdata.attr);
          default:            rd_d = 32'(ram_rdata.ctl);
        endcase
      end
    end else if (mode_q == lpic_pkg::MODE_READ) begin
      if (addr_q == lpic_pkg::ADDR_CFG)         rd_d = 32'(cfg_q);
      else if (addr_q == lpic_pkg::ADDR_INFO)   rd_d = lpic_pkg::INFO_WORD;
      else if (addr_q == lpic_pkg::ADDR_THRESH) rd_d = 32'(thr_q);
    end else if (mode_q == lpic_pkg::MODE_WRITE) begin
      if (addr_q == lpic_pkg::ADDR_CFG)         cfg_d = wd_q;
      else if (addr_q == lpic_pkg::ADDR_THRESH) thr_d = wd_q;
    end
    unique case (mode_q)
      lpic_pkg::MODE_WRITE: begin
        unique case (addr_q[1:0])
          lpic_pkg::SUB_PEND: if (ram_rdata.attr[1]) rec_new.pend = wd_q[0];
          lpic_pkg::SUB_EN:   rec_new.en = wd_q;
          lpic_pkg::SUB_ATTR: rec_new.attr = wd_q;
          default:            rec_new.ctl = wd_q;
        endcase
      end
      lpic_pkg::MODE_LINE: begin
        if (!ram_rdata.attr[1]) begin
          rec_new.pend = lvl_q;
        end else if (!ram_rdata.attr[2] && !ram_rdata.last && lvl_q) begin
          rec_new.pend = 1'b1;
        end else if (ram_rdata.attr[2] && ram_rdata.last && !lvl_q) begin
          rec_new.pend = 1'b1;
        end
        rec_new.last = lvl_q;
      end
      lpic_pkg::MODE_CLAIM: begin
        if (ram_rdata.attr[1]) rec_new.pend = 1'b0;
      end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    in_ready_o = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = cnt_q;
    ram_wdata  = '0;
    ram_re     = 1'b0;
    ram_raddr  = cnt_q;
    scan_vld_d = 1'b0;
    arb_clear  = 1'b0;
    load_out   = 1'b0;
    unique case (state_q)
      lpic_pkg::ST_CLR: begin
        ram_we = 1'b1;
        cnt_d  = cnt_q + 1'b1;
        if (32'(cnt_q) == lpic_pkg::SOURCE_COUNT - 1) begin
          cnt_d   = '0;
          state_d = lpic_pkg::ST_IDLE;
        end
      end
      lpic_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        ram_re     = accept;
        ram_raddr  = idx_d;
        if (accept) state_d = lpic_pkg::ST_MOD;
      end
      lpic_pkg::ST_MOD: begin
        ram_we    = hit_q && (mode_q != lpic_pkg::MODE_READ);
        ram_waddr = idx_q;
        ram_wdata = rec_new;
        arb_clear = 1'b1;
        cnt_d     = '0;
        state_d   = lpic_pkg::ST_SCAN;
      end
      lpic_pkg::ST_SCAN: begin
        ram_re     = 1'b1;
        scan_vld_d = 1'b1;
        cnt_d      = cnt_q + 1'b1;
        if (32'(cnt_q) == lpic_pkg::SOURCE_COUNT - 1) begin
          cnt_d   = '0;
          state_d = lpic_pkg::ST_DRAIN;
        end
      end
      lpic_pkg::ST_DRAIN: begin
        state_d = lpic_pkg::ST_FIN;
      end
      lpic_pkg::ST_FIN: begin
        if (!out_vld_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = lpic_pkg::ST_IDLE;
        end
      end
      default: state_d = lpic_pkg::ST_IDLE;
    endcase
  end

  // output word valid
  always_comb begin
    out_vld_d = out_vld_q;
    if (out_vld_q && out_ready_i) out_vld_d = 1'b0;
    if (load_out) out_vld_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= lpic_pkg::ST_CLR;
      cnt_q      <= '0;
      cfg_q      <= '0;
      thr_q      <= '0;
      scan_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      scan_vld_q <= scan_vld_d;
      out_vld_q  <= out_vld_d;
      if (state_q == lpic_pkg::ST_MOD) begin
        cfg_q <= cfg_d;
        thr_q <= thr_d;
      end
    end
  end

  // word capture and result registers
  always_ff @(posedge clk_i) begin
    scan_id_q <= cnt_q;
    if (accept) begin
      mode_q <= mode_i;
      addr_q <= address_i;
      wd_q   <= write_data_i;
      lvl_q  <= line_level_i;
      hit_q  <= hit_d;
      idx_q  <= idx_d;
    end
    if (state_q == lpic_pkg::ST_MOD) rd_q <= rd_d;
    if (load_out) begin
      out_rd_q  <= rd_q;
      out_res_q <= best;
    end
  end

  lpic_ram #(
    .DEPTH (lpic_pkg::SOURCE_COUNT),
    .WIDTH (lpic_pkg::REC_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  lpic_arb u_arb (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clear_i  (arb_clear),
    .valid_i  (scan_vld_q),
    .id_i     (scan_id_q),
    .rec_i    (ram_rdata),
    .cfg_i    (cfg_q),
    .thresh_i (thr_q),
    .res_o    (best)
  );

  assign out_valid_o    = out_vld_q;
  assign read_data_o    = out_rd_q;
  assign irq_valid_o    = out_res_q.found;
  assign irq_id_o       = 6'(out_res_q.id);
  assign irq_vectored_o = out_res_q.vec;
  assign irq_level_o    = out_res_q.lvl;

  `LPIC_ASSERT_SAME(a_clr_blocks_in, state_q == lpic_pkg::ST_CLR, !in_ready_o)
  `LPIC_ASSERT_SAME(a_we_phase, ram_we, state_q == lpic_pkg::ST_CLR || state_q == lpic_pkg::ST_MOD)
  `LPIC_ASSERT_NEXT(a_accept_to_mod, accept, state_q == lpic_pkg::ST_MOD)
  `LPIC_ASSERT_SAME(a_no_irq_zero, out_valid_o && !irq_valid_o, irq_id_o == 6'd0 && irq_level_o == 8'd0 && !irq_vectored_o)

endmodule

// ===== tb/sv/level_priority_interrupt_controller_checker.sv =====
// ----------------------------------------------------------------------------
// level_priority_interrupt_controller_checker
// Watches both channels of the interrupt controller, keeps its own copy of the
// per-source state, predicts each result word and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module level_priority_interrupt_controller_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  mode_i,
  input  logic [12:0] address_i,
  input  logic [7:0]  write_data_i,
  input  logic [5:0]  source_i,
  input  logic        line_level_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] read_data_i,
  input  logic        irq_valid_i,
  input  logic [5:0]  irq_id_i,
  input  logic        irq_vectored_i,
  input  logic [7:0]  irq_level_i,
  output int          fail_count_o,
  output int          pending_count_o,
  output int          words_checked_o,
  output int          irq_offers_o
);

  typedef struct packed {
    logic [31:0] rdata;
    logic        vld;
    logic [5:0]  id;
    logic        vec;
    logic [7:0]  lvl;
  } irq_offer_t;

  // shadow of the controller state
  logic       pend_q   [lpic_pkg::SOURCE_COUNT];
  logic       line_q   [lpic_pkg::SOURCE_COUNT];
  logic [7:0] enable_q [lpic_pkg::SOURCE_COUNT];
  logic [7:0] attr_q   [lpic_pkg::SOURCE_COUNT];
  logic [7:0] ctl_q    [lpic_pkg::SOURCE_COUNT];
  logic [7:0] cfg_q;
  logic [7:0] thresh_q;

  irq_offer_t expected_offers_q[$];

  assign pending_count_o = expected_offers_q.size();

  function automatic logic [7:0] decoded_level(logic [7:0] ctl, int n);
    if (n == 0) return 8'hFF;
    return (ctl & (8'hFF << (8 - n))) | (8'hFF >> n);
  endfunction

  function automatic logic [7:0] decoded_prio(logic [7:0] ctl, int n);
    int pw;
    pw = lpic_pkg::CTL_BITS - n;
    if (pw == 0) return 8'd0;
    return 8'((int'(ctl) >> (8 - lpic_pkg::CTL_BITS)) & ((1 << pw) - 1));
  endfunction

  // apply one word to the shadow state and return the offer it leads to
  task automatic predict_controller_step(input logic [1:0] mode, input logic [12:0] addr,
                                         input logic [7:0] data, input logic [5:0] src,
                                         input logic lvl, output irq_offer_t res);
    int idx;
    int n;
    logic [1:0] trig;
    logic [15:0] key, best_key;
    res = '0;
    best_key = '0;
    idx = (addr >= lpic_pkg::ADDR_SRC_BASE) ?
          (int'(addr) - int'(lpic_pkg::ADDR_SRC_BASE)) >> 2 : -1;
    case (mode)
      lpic_pkg::MODE_READ: begin
        if (addr >= lpic_pkg::ADDR_SRC_BASE) begin
          if (idx < lpic_pkg::SOURCE_COUNT) begin
            case (addr[1:0])
              lpic_pkg::SUB_PEND: res.rdata = 32'(pend_q[idx]);
              lpic_pkg::SUB_EN:   res.rdata = 32'(enable_q[idx]);
              lpic_pkg::SUB_ATTR: res.rdata = 32'(attr_q[idx]);
              default:            res.rdata = 32'(ctl_q[idx]);
            endcase
          end
        end else if (addr == lpic_pkg::ADDR_CFG) res.rdata = 32'(cfg_q);
        else if (addr == lpic_pkg::ADDR_INFO) res.rdata = lpic_pkg::INFO_WORD;
        else if (addr == lpic_pkg::ADDR_THRESH) res.rdata = 32'(thresh_q);
      end
      lpic_pkg::MODE_WRITE: begin
        if (addr >= lpic_pkg::ADDR_SRC_BASE) begin
          if (idx < lpic_pkg::SOURCE_COUNT) begin
            case (addr[1:0])
              lpic_pkg::SUB_PEND: if (attr_q[idx][1]) pend_q[idx] = data[0];
              lpic_pkg::SUB_EN:   enable_q[idx] = data;
              lpic_pkg::SUB_ATTR: attr_q[idx] = data;
              default:            ctl_q[idx] = data;
            endcase
          end
        end else if (addr == lpic_pkg::ADDR_CFG) cfg_q = data;
        else if (addr == lpic_pkg::ADDR_THRESH) thresh_q = data;
      end
      lpic_pkg::MODE_LINE: begin
        trig = attr_q[src][2:1];
        if (!trig[0]) pend_q[src] = lvl;
        else if (trig == 2'd1 && !line_q[src] && lvl) pend_q[src] = 1'b1;
        else if (trig == 2'd3 && line_q[src] && !lvl) pend_q[src] = 1'b1;
        line_q[src] = lvl;
      end
      default: if (attr_q[src][1]) pend_q[src] = 1'b0;
    endcase

    // rank: level, then priority, ties to the higher id
    n = (int'(cfg_q[4:1]) > lpic_pkg::CTL_BITS) ? lpic_pkg::CTL_BITS : int'(cfg_q[4:1]);
    for (int i = 0; i < lpic_pkg::SOURCE_COUNT; i++) begin
      logic [7:0] l;
      l = decoded_level(ctl_q[i], n);
      if (pend_q[i] && enable_q[i][0] && l >= thresh_q) begin
        key = {l, decoded_prio(ctl_q[i], n)};
        if (!res.vld || key >= best_key) begin
          res.vld = 1'b1;
          best_key = key;
          res.id = 6'(i);
          res.vec = attr_q[i][0];
          res.lvl = l;
        end
      end
    end
  endtask

  // predict on input accept, compare on output accept
  always @(posedge clk_i or negedge rst_ni) begin
    irq_offer_t exp_w;
    irq_offer_t got_w;
    if (!rst_ni) begin
      for (int i = 0; i < lpic_pkg::SOURCE_COUNT; i++) begin
        pend_q[i] = 1'b0; line_q[i] = 1'b0;
        enable_q[i] = '0; attr_q[i] = '0; ctl_q[i] = '0;
      end
      cfg_q = '0;
      thresh_q = '0;
      expected_offers_q.delete();
      fail_count_o <= 0;
      words_checked_o <= 0;
      irq_offers_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        predict_controller_step(mode_i, address_i, write_data_i, source_i, line_level_i,
                                exp_w);
        expected_offers_q.push_back(exp_w);
      end
      if (out_valid_i && out_ready_i) begin
        got_w = '{read_data_i, irq_valid_i, irq_id_i, irq_vectored_i, irq_level_i};
        words_checked_o <= words_checked_o + 1;
        if (irq_valid_i) irq_offers_o <= irq_offers_o + 1;
        if (expected_offers_q.size() == 0) begin
          if (fail_count_o < 10)
            $display("%0t: unexpected result word rd=%h irq=%b id=%0d", $realtime,
                     read_data_i, irq_valid_i, irq_id_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_w = expected_offers_q.pop_front();
          if (got_w !== exp_w) begin
            if (fail_count_o < 10)
              $display({"%0t: mismatch exp rd=%h vld=%b id=%0d vec=%b lvl=%h",
                        " | got rd=%h vld=%b id=%0d vec=%b lvl=%h"},
                       $realtime, exp_w.rdata, exp_w.vld, exp_w.id, exp_w.vec, exp_w.lvl,
                       got_w.rdata, got_w.vld, got_w.id, got_w.vec, got_w.lvl);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives register accesses, line changes and claims into the interrupt
// controller under random flow control; the checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int RANDOM_WORDS = 780;
  localparam int STALL_LIMIT  = 5000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  mode_i = lpic_pkg::MODE_READ;
  logic [12:0] address_i = '0;
  logic [7:0]  write_data_i = '0;
  logic [5:0]  source_i = '0;
  logic        line_level_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] read_data_o;
  logic        irq_valid_o;
  logic [5:0]  irq_id_o;
  logic        irq_vectored_o;
  logic [7:0]  irq_level_o;

  int fail_count, pending_count, words_checked, irq_offers;
  int send_idle_pct = 33;
  int recv_idle_pct = 50;
  int stall_cycles = 0;

  level_priority_interrupt_controller u_dut (.*);

  level_priority_interrupt_controller_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .mode_i, .address_i,
    .write_data_i, .source_i, .line_level_i, .out_valid_i(out_valid_o), .out_ready_i,
    .read_data_i(read_data_o), .irq_valid_i(irq_valid_o), .irq_id_i(irq_id_o),
    .irq_vectored_i(irq_vectored_o), .irq_level_i(irq_level_o),
    .fail_count_o(fail_count), .pending_count_o(pending_count),
    .words_checked_o(words_checked), .irq_offers_o(irq_offers)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // receiver flow control
  always @(posedge clk_i) out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);

  // watchdog on cycles with no accept on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_word(input logic [1:0] mode, input logic [12:0] addr,
                           input logic [7:0] data, input logic [5:0] src, input logic lvl);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    mode_i       <= mode;
    address_i    <= addr;
    write_data_i <= data;
    source_i     <= src;
    line_level_i <= lvl;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  function automatic logic [12:0] src_addr(int id, logic [1:0] sub);
    return lpic_pkg::ADDR_SRC_BASE + 13'(id * 4) + 13'(sub);
  endfunction

  // one random word, mostly meaningful register traffic and line activity
  task automatic send_random_word();
    int pick;
    int id;
    logic [12:0] addr;
    logic [7:0] data;
    pick = $urandom_range(0, 99);
    id = $urandom_range(0, 63);
    data = 8'($urandom);
    if (pick < 12) begin
      case ($urandom_range(0, 3))
        0: addr = 13'($urandom);
        1: addr = src_addr(id, 2'($urandom));
        2: addr = ($urandom_range(0, 1)) ? lpic_pkg::ADDR_CFG : lpic_pkg::ADDR_THRESH;
        default: addr = lpic_pkg::ADDR_INFO;
      endcase
      send_word(lpic_pkg::MODE_READ, addr, data, 6'($urandom), 1'($urandom));
    end else if (pick < 45) begin
      case ($urandom_range(0, 9))
        0: addr = lpic_pkg::ADDR_CFG;
        1: begin
          addr = lpic_pkg::ADDR_THRESH;
          if ($urandom_range(0, 3) != 0) data = 8'($urandom_range(0, 80));
        end
        2: addr = 13'($urandom);
        3: addr = src_addr(id, lpic_pkg::SUB_PEND);
        4, 5: addr = src_addr(id, lpic_pkg::SUB_EN);
        6, 7: addr = src_addr(id, lpic_pkg::SUB_ATTR);
        default: addr = src_addr(id, lpic_pkg::SUB_CTL);
      endcase
      send_word(lpic_pkg::MODE_WRITE, addr, data, 6'($urandom), 1'($urandom));
    end else if (pick < 82) begin
      send_word(lpic_pkg::MODE_LINE, 13'($urandom), data, 6'(id), 1'($urandom));
    end else begin
      send_word(lpic_pkg::MODE_CLAIM, 13'($urandom), data, 6'(id), 1'($urandom));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: global registers, unmapped and out-of-range addresses
    send_word(lpic_pkg::MODE_READ,  lpic_pkg::ADDR_INFO, 8'h00, 6'd0, 1'b0);
    send_word(lpic_pkg::MODE_WRITE, lpic_pkg::ADDR_INFO, 8'hFF, 6'd0, 1'b0);
    send_word(lpic_pkg::MODE_READ,  13'h008, 8'h00, 6'd0, 1'b0);
    send_word(lpic_pkg::MODE_WRITE, src_addr(64, lpic_pkg::SUB_EN), 8'hFF, 6'd0, 1'b0);
    send_word(lpic_pkg::MODE_READ,  13'h1FFF, 8'h00, 6'd63, 1'b1);
    send_word(lpic_pkg::MODE_WRITE, src_addr(63, lpic_pkg::SUB_EN), 8'h01, 6'd0, 1'b0);
    send_word(lpic_pkg::MODE_WRITE, src_addr(0, lpic_pkg::SUB_EN), 8'hFF, 6'd0, 1'b0);
    // level source follows its line, pending write ignored
    send_word(lpic_pkg::MODE_LINE,  13'h0, 8'h0, 6'd63, 1'b1);
    send_word(lpic_pkg::MODE_WRITE, src_addr(63, lpic_pkg::SUB_PEND), 8'h00, 6'd0, 1'b0);
    send_word(lpic_pkg::MODE_CLAIM, 13'h0, 8'h0, 6'd63, 1'b0);
    // rising-edge source with vectored bit set, and a falling-edge source
    send_word(lpic_pkg::MODE_WRITE, src_addr(0, lpic_pkg::SUB_ATTR), 8'h03, 6'd0, 1'b0);
    send_word(lpic_pkg::MODE_LINE,  13'h0, 8'h0, 6'd0, 1'b1);
    send_word(lpic_pkg::MODE_WRITE, src_addr(63, lpic_pkg::SUB_ATTR), 8'h06, 6'd0, 1'b0);
    send_word(lpic_pkg::MODE_LINE,  13'h0, 8'h0, 6'd63, 1'b0);
    send_word(lpic_pkg::MODE_WRITE, src_addr(0, lpic_pkg::SUB_CTL), 8'hFF, 6'd0, 1'b0);
    // level bits at zero, at the cap and beyond it
    send_word(lpic_pkg::MODE_WRITE, lpic_pkg::ADDR_CFG, 8'h08, 6'd0, 1'b0);
    send_word(lpic_pkg::MODE_WRITE, lpic_pkg::ADDR_CFG, 8'hFF, 6'd0, 1'b0);
    send_word(lpic_pkg::MODE_READ,  lpic_pkg::ADDR_CFG, 8'h00, 6'd0, 1'b0);
    send_word(lpic_pkg::MODE_WRITE, lpic_pkg::ADDR_THRESH, 8'hFF, 6'd0, 1'b0);
    send_word(lpic_pkg::MODE_READ,  lpic_pkg::ADDR_THRESH, 8'h00, 6'd0, 1'b0);
    send_word(lpic_pkg::MODE_WRITE, lpic_pkg::ADDR_THRESH, 8'h00, 6'd0, 1'b0);
    send_word(lpic_pkg::MODE_CLAIM, 13'h0, 8'h0, 6'd0, 1'b0);
    send_word(lpic_pkg::MODE_WRITE, src_addr(63, lpic_pkg::SUB_PEND), 8'h01, 6'd0, 1'b0);
    send_word(lpic_pkg::MODE_READ,  src_addr(63, lpic_pkg::SUB_PEND), 8'h00, 6'd0, 1'b0);
    send_word(lpic_pkg::MODE_WRITE, lpic_pkg::ADDR_CFG, 8'h00, 6'd0, 1'b0);

    // random: three flow-control phases
    for (int k = 0; k < RANDOM_WORDS; k++) begin
      if (k == RANDOM_WORDS / 3) begin
        send_idle_pct = 50;
        recv_idle_pct = 33;
      end else if (k == 2 * RANDOM_WORDS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      send_random_word();
    end
    in_valid_i <= 1'b0;

    while (pending_count != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    $display("Checked %0d result words, %0d of them offering an interrupt.",
             words_checked, irq_offers);
    $display("Failures counted: %0d", fail_count);
    if (fail_count == 0 && pending_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
